>>> hw/rtl/brds_pkg.sv
// Shared types and constants for the bounded rewetting dose sequencer.
// Holds the band, outcome, result and register index codes and the result item layout.
// No dependencies.
`default_nettype none

package brds_pkg;

  // Sensor reading width; narrower sensors are masked to this many bits
  localparam int READING_BITS = 16;

  localparam int FIELD_W = 16;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W = 3;

  // Keep only the low READING_BITS bits of a reading
  localparam logic [FIELD_W-1:0] READING_MASK = {FIELD_W{1'b1}} >> (FIELD_W - READING_BITS);

  // Minimum gap between the act and hold thresholds for valid bands
  localparam logic [FIELD_W:0] BAND_GAP = 17'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACT_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABSORB_DROP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH_MS = 3'd4;

  typedef enum logic [1:0] {
    BAND_ACT  = 2'd0,
    BAND_HOLD = 2'd1,
    BAND_WAIT = 2'd2
  } band_t;

  typedef enum logic [1:0] {
    OUT_ABSORBED     = 2'd0,
    OUT_RAN_THROUGH  = 2'd1,
    OUT_INCONCLUSIVE = 2'd2,
    OUT_NONE         = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    RES_TARGET      = 2'd0,
    RES_PASSTHROUGH = 2'd1,
    RES_BOUND       = 2'd2
  } result_t;

  // Result item, first field in the lowest bits (packed structs list MSB first)
  typedef struct packed {
    logic                bands_valid;
    logic [COUNT_W-1:0]  ran_through_count;
    logic [COUNT_W-1:0]  absorbed_count;
    logic [COUNT_W-1:0]  pulses_done;
    logic [FIELD_W-1:0]  end_reading;
    logic [FIELD_W-1:0]  start_reading;
    result_t             cycle_result;
    band_t               reading_band;
    outcome_t            pulse_outcome;
    logic [FIELD_W-1:0]  pulse_duration;
    logic                pulse_request;
  } result_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/bounded_rewetting_dose_sequencer.sv
// Bounded rewetting dose sequencer: top level, single registered stage.
// Depends on brds_pkg for codes and the result item layout.
//
// Usage:
//   Input stream s_*: one settled moisture reading per transaction.
//     s_tdata[15:0] raw_reading (higher is drier), s_tdata[16] runoff_seen.
//   Output stream m_*: exactly one result per reading, in order.
//     m_tlast marks the result that ends a watering cycle (cycle_done).
//   Config: cfg_we/cfg_index/cfg_data write one configuration register per
//     cycle; write only while no reading is in flight.
//   Timing: a reading accepted at a clock edge is presented on m_* right
//     after that edge, from the result register.
//     Throughput: one reading per cycle while m_tready is high; the cycle state
//     and counters update in the same cycle as the result register, so
//     back-to-back readings need no bubbles.
//   Stall: the result register holds while m_tready is low; s_tready drops
//     only when that register is full and not being taken.
//   Reset (rst, synchronous): registers return to their defaults, the
//     block is idle (no cycle open) and the output register is empty.
`default_nettype none

module bounded_rewetting_dose_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [15:0] raw_reading, [16] runoff_seen, [23:17] zero
  input  wire logic [23:0] s_tdata,
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] pulse_request, [16:1] pulse_duration, [18:17] pulse_outcome,
  // [20:19] reading_band, [22:21] cycle_result, [38:23] start_reading,
  // [54:39] end_reading, [62:55] pulses_done, [70:63] absorbed_count,
  // [78:71] ran_through_count, [79] bands_valid
  output logic [79:0]      m_tdata,
  output logic             m_tlast,   // cycle_done
  // Configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [brds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brds_pkg::FIELD_W-1:0]   cfg_data
);

  import brds_pkg::*;

  // Configuration registers
  logic [FIELD_W-1:0] act_threshold;
  logic [FIELD_W-1:0] hold_threshold;
  logic [FIELD_W-1:0] absorb_drop;
  logic [COUNT_W-1:0] pulse_limit;
  logic [FIELD_W-1:0] pulse_length_ms;

  // Cycle state
  logic               in_cycle;
  logic [FIELD_W-1:0] last_reading;
  logic [FIELD_W-1:0] first_reading;
  logic [COUNT_W-1:0] pulse_counter;
  logic [COUNT_W-1:0] absorbed_counter;
  logic [COUNT_W-1:0] ranthrough_counter;

  // Output register
  result_item_t       out_item;
  logic               out_done;

  // Combinational step
  logic               s_acc;
  logic [FIELD_W-1:0] raw;
  logic               runoff;
  band_t              band;
  outcome_t           outcome;
  logic               absorbed_hit;
  logic               pulse;
  logic               done;
  result_t            result;
  logic               bands_ok;
  logic               in_cycle_next;
  logic [FIELD_W-1:0] first_reading_next;
  logic [COUNT_W-1:0] pulse_counter_next;
  logic [COUNT_W-1:0] absorbed_counter_next;
  logic [COUNT_W-1:0] ranthrough_counter_next;
  result_item_t       out_item_next;

  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;

  // Mask the reading to the sensor width
  assign raw    = s_tdata[FIELD_W-1:0] & READING_MASK;
  assign runoff = s_tdata[FIELD_W];

  // Classify the reading; act wins over hold when bands overlap
  always_comb begin
    if (raw >= act_threshold) begin
      band = BAND_ACT;
    end else if (raw <= hold_threshold) begin
      band = BAND_HOLD;
    end else begin
      band = BAND_WAIT;
    end
  end

  // Signed drop last - raw >= absorb_drop, rearranged to stay unsigned
  assign absorbed_hit = {1'b0, last_reading} >= ({1'b0, raw} + {1'b0, absorb_drop});

  assign bands_ok = (pulse_limit != '0) &&
                    ({1'b0, act_threshold} >= ({1'b0, hold_threshold} + BAND_GAP));

  // Judge the last pulse, update counts and decide whether the cycle ends
  always_comb begin
    outcome                 = OUT_NONE;
    done                    = 1'b0;
    result                  = RES_TARGET;
    pulse                   = 1'b0;
    first_reading_next      = first_reading;
    pulse_counter_next      = pulse_counter;
    absorbed_counter_next   = absorbed_counter;
    ranthrough_counter_next = ranthrough_counter;

    if (!in_cycle) begin
      first_reading_next      = raw;
      pulse_counter_next      = '0;
      absorbed_counter_next   = '0;
      ranthrough_counter_next = '0;
      if (band != BAND_ACT) begin
        done = 1'b1;
      end
    end else begin
      if (absorbed_hit) begin
        outcome = OUT_ABSORBED;
      end else if (runoff) begin
        outcome = OUT_RAN_THROUGH;
      end else begin
        outcome = OUT_INCONCLUSIVE;
      end
      if (outcome == OUT_ABSORBED) begin
        absorbed_counter_next = absorbed_counter + 1'b1;
      end
      if (outcome == OUT_RAN_THROUGH) begin
        ranthrough_counter_next = ranthrough_counter + 1'b1;
        done   = 1'b1;
        result = RES_PASSTHROUGH;
      end else if (band != BAND_ACT) begin
        done = 1'b1;
      end
    end

    // Request another pulse unless the bound is reached
    if (!done) begin
      if (pulse_counter_next >= pulse_limit) begin
        done   = 1'b1;
        result = RES_BOUND;
      end else begin
        pulse              = 1'b1;
        pulse_counter_next = pulse_counter_next + 1'b1;
      end
    end

    in_cycle_next = !done;
  end

  // Assemble the result item
  always_comb begin
    out_item_next.pulse_request     = pulse;
    out_item_next.pulse_duration    = pulse ? pulse_length_ms : '0;
    out_item_next.pulse_outcome     = outcome;
    out_item_next.reading_band      = band;
    out_item_next.cycle_result      = done ? result : RES_TARGET;
    out_item_next.start_reading     = first_reading_next;
    out_item_next.end_reading       = raw;
    out_item_next.pulses_done       = pulse_counter_next;
    out_item_next.absorbed_count    = absorbed_counter_next;
    out_item_next.ran_through_count = ranthrough_counter_next;
    out_item_next.bands_valid       = bands_ok;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      act_threshold   <= 16'd65535;
      hold_threshold  <= 16'd0;
      absorb_drop     <= 16'd1;
      pulse_limit     <= 8'd4;
      pulse_length_ms <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACT_THRESHOLD:   act_threshold   <= cfg_data;
        REG_HOLD_THRESHOLD:  hold_threshold  <= cfg_data;
        REG_ABSORB_DROP:     absorb_drop     <= cfg_data;
        REG_PULSE_LIMIT:     pulse_limit     <= cfg_data[COUNT_W-1:0];
        REG_PULSE_LENGTH_MS: pulse_length_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance cycle state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_cycle           <= 1'b0;
      last_reading       <= '0;
      first_reading      <= '0;
      pulse_counter      <= '0;
      absorbed_counter   <= '0;
      ranthrough_counter <= '0;
    end else if (s_acc) begin
      in_cycle           <= in_cycle_next;
      last_reading       <= raw;
      first_reading      <= first_reading_next;
      pulse_counter      <= pulse_counter_next;
      absorbed_counter   <= absorbed_counter_next;
      ranthrough_counter <= ranthrough_counter_next;
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      out_item <= out_item_next;
      out_done <= done;
    end
  end

  assign m_tdata = out_item;
  assign m_tlast = out_done;

`ifndef SYNTHESIS
  // A result that ends the cycle never requests a pulse
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !out_item.pulse_request)
    else $error("pulse requested on cycle end");

  // A pulse request always counts itself
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_item.pulse_request) |-> (out_item.pulses_done != '0))
    else $error("pulse request with zero pulse count");

  // A starting reading judges nothing and carries cleared outcome counts
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_item.pulse_outcome == OUT_NONE) |->
      (out_item.absorbed_count == '0 && out_item.ran_through_count == '0))
    else $error("counts not cleared at cycle start");

  // Ending a cycle leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    (s_acc && done) |=> !in_cycle)
    else $error("cycle still open after end");

  // Reset empties the output register and closes any cycle
  assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_cycle))
    else $error("state not cleared by reset");
`endif

endmodule

`default_nettype wire

>>> verif/brds_checker.sv
// Scoreboard for the bounded rewetting dose sequencer: watches both streams and the
// register write port, predicts every result and compares it field by field.
// Depends on brds_pkg for the codes, register indexes and the result item layout.
`timescale 1ns / 100ps

module brds_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [23:0]                    s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [79:0]                    m_tdata,
  input  logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [brds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [brds_pkg::FIELD_W-1:0]   cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  import brds_pkg::*;

  typedef struct packed {
    result_item_t item;
    logic         done;
  } dose_expect_t;

  // Expected results, oldest first
  dose_expect_t dose_q[$];

  // Shadow copy of the registers
  logic [FIELD_W-1:0] act_thr, hold_thr, min_drop, dose_len;
  logic [COUNT_W-1:0] pulse_cap;

  // Shadow copy of the watering cycle state
  logic               cycle_open;
  logic [FIELD_W-1:0] prev_rd, first_rd;
  logic [COUNT_W-1:0] pulse_cnt, absorb_cnt, runthru_cnt;

  initial mismatches = 0;

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic band_t band_of_reading(input logic [FIELD_W-1:0] rd);
    if (rd >= act_thr) return BAND_ACT;
    if (rd <= hold_thr) return BAND_HOLD;
    return BAND_WAIT;
  endfunction

  // Advance the shadow cycle state by one reading and build its result
  function automatic dose_expect_t predict_dose(input logic [FIELD_W-1:0] rd, input logic runoff);
    dose_expect_t exp_r;
    band_t        band;
    outcome_t     verdict;
    result_t      res;
    logic         pulse, done;
    int           drop;
    int           pre_i, post_i;
    band = band_of_reading(rd);
    verdict = OUT_NONE;
    res = RES_TARGET;
    pulse = 1'b0;
    done = 1'b0;
    if (!cycle_open) begin
      // Starting reading: runoff is ignored here
      first_rd = rd;
      pulse_cnt = '0;
      absorb_cnt = '0;
      runthru_cnt = '0;
      if (band != BAND_ACT) done = 1'b1;
    end else begin
      // Judge the last pulse on the signed wet-ward drop
      pre_i = prev_rd;
      post_i = rd;
      drop = pre_i - post_i;
      if (drop >= int'(min_drop)) verdict = OUT_ABSORBED;
      else if (runoff) verdict = OUT_RAN_THROUGH;
      else verdict = OUT_INCONCLUSIVE;
      if (verdict == OUT_ABSORBED) absorb_cnt = absorb_cnt + 1'b1;
      if (verdict == OUT_RAN_THROUGH) runthru_cnt = runthru_cnt + 1'b1;
      if (verdict == OUT_RAN_THROUGH) begin
        done = 1'b1;
        res = RES_PASSTHROUGH;
      end else if (band != BAND_ACT) begin
        done = 1'b1;
      end
    end
    // Pulse again unless the bound is used up
    if (!done) begin
      if (pulse_cnt >= pulse_cap) begin
        done = 1'b1;
        res = RES_BOUND;
      end else begin
        pulse = 1'b1;
        pulse_cnt = pulse_cnt + 1'b1;
      end
    end
    prev_rd = rd;
    cycle_open = !done;

    exp_r.done = done;
    exp_r.item.pulse_request = pulse;
    exp_r.item.pulse_duration = pulse ? dose_len : '0;
    exp_r.item.pulse_outcome = verdict;
    exp_r.item.reading_band = band;
    exp_r.item.cycle_result = done ? res : RES_TARGET;
    exp_r.item.start_reading = first_rd;
    exp_r.item.end_reading = rd;
    exp_r.item.pulses_done = pulse_cnt;
    exp_r.item.absorbed_count = absorb_cnt;
    exp_r.item.ran_through_count = runthru_cnt;
    exp_r.item.bands_valid = (pulse_cap != '0) &&
                             ({1'b0, act_thr} >= {1'b0, hold_thr} + BAND_GAP);
    return exp_r;
  endfunction

  always @(posedge clk) begin
    result_item_t seen;
    dose_expect_t want;
    if (rst) begin
      act_thr = 16'hFFFF;
      hold_thr = '0;
      min_drop = 16'd1;
      pulse_cap = 8'd4;
      dose_len = 16'd1000;
      cycle_open = 1'b0;
      prev_rd = '0;
      first_rd = '0;
      pulse_cnt = '0;
      absorb_cnt = '0;
      runthru_cnt = '0;
      dose_q.delete();
      outstanding <= 0;
    end else begin
      // Compare the result transaction with the oldest expectation
      if (m_tvalid && m_tready) begin
        seen = result_item_t'(m_tdata);
        if (dose_q.size() == 0) begin
          note_mismatch("result with no reading waiting");
        end else begin
          want = dose_q.pop_front();
          check_field("pulse_request", seen.pulse_request, want.item.pulse_request);
          check_field("pulse_duration", seen.pulse_duration, want.item.pulse_duration);
          check_field("pulse_outcome", seen.pulse_outcome, want.item.pulse_outcome);
          check_field("reading_band", seen.reading_band, want.item.reading_band);
          check_field("cycle_done", m_tlast, want.done);
          check_field("cycle_result", seen.cycle_result, want.item.cycle_result);
          check_field("start_reading", seen.start_reading, want.item.start_reading);
          check_field("end_reading", seen.end_reading, want.item.end_reading);
          check_field("pulses_done", seen.pulses_done, want.item.pulses_done);
          check_field("absorbed_count", seen.absorbed_count, want.item.absorbed_count);
          check_field("ran_through_count", seen.ran_through_count,
                      want.item.ran_through_count);
          check_field("bands_valid", seen.bands_valid, want.item.bands_valid);
        end
      end
      // Predict the reading transaction with the registers as they stand
      if (s_tvalid && s_tready) begin
        dose_q.push_back(predict_dose(s_tdata[FIELD_W-1:0] & READING_MASK,
                                      s_tdata[FIELD_W]));
      end
      // Register writes take effect from the next reading
      if (cfg_we) begin
        case (cfg_index)
          REG_ACT_THRESHOLD:   act_thr = cfg_data;
          REG_HOLD_THRESHOLD:  hold_thr = cfg_data;
          REG_ABSORB_DROP:     min_drop = cfg_data;
          REG_PULSE_LIMIT:     pulse_cap = cfg_data[COUNT_W-1:0];
          REG_PULSE_LENGTH_MS: dose_len = cfg_data;
          default: ;
        endcase
      end
      outstanding <= dose_q.size();
    end
  end

endmodule

>>> verif/tb_bounded_rewetting_dose_sequencer.sv
// Testbench top for the bounded rewetting dose sequencer: drives readings, register
// writes and result back-pressure, and gives the verdict from brds_checker's count.
// Depends on brds_pkg, brds_checker and the block itself.
`timescale 1ns / 100ps

module tb_bounded_rewetting_dose_sequencer;
  import brds_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [79:0]          m_tdata;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ACT_THRESHOLD;
  logic [FIELD_W-1:0]   cfg_data = '0;

  int mismatches;
  int outstanding;

  // Idle chances in percent, and a token that asks the receiver for a long hold-off
  int send_idle = 0;
  int recv_idle = 0;
  int hold_token = 0;

  // Register values as last written, used to aim the random readings
  int act_v = 65535;
  int hold_v = 0;
  int drop_v = 1;
  int cur_rd = 0;

  always #6 clk = ~clk;

  bounded_rewetting_dose_sequencer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  brds_checker scoreboard (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Result back-pressure: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    int hold_seen;
    int hold_left;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offer one reading and hold it until the block takes it
  task automatic send_reading(input logic [15:0] rd, input logic runoff);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, runoff, rd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every result has been taken
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write all five registers back to back; the limit gets junk in its unused bits
  task automatic program_regs(input int act, input int hold, input int drop,
                              input int limit, input int len);
    cfg_we <= 1'b1;
    cfg_index <= REG_ACT_THRESHOLD;
    cfg_data <= act[15:0];
    @(posedge clk);
    cfg_index <= REG_HOLD_THRESHOLD;
    cfg_data <= hold[15:0];
    @(posedge clk);
    cfg_index <= REG_ABSORB_DROP;
    cfg_data <= drop[15:0];
    @(posedge clk);
    cfg_index <= REG_PULSE_LIMIT;
    cfg_data <= {8'($urandom_range(255)), limit[7:0]};
    @(posedge clk);
    cfg_index <= REG_PULSE_LENGTH_MS;
    cfg_data <= len[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    act_v = act;
    hold_v = hold;
    drop_v = drop;
  endtask

  // Pick a register setting, mostly with a sane wait gap
  task automatic random_regs;
    int act, hold, drop, limit;
    case ($urandom_range(9))
      0: act = 0;
      1: act = 65535;
      default: act = $urandom_range(60000, 20000);
    endcase
    case ($urandom_range(9))
      0: hold = act;
      1: hold = act - 1;
      2: hold = act - 2;
      3: hold = $urandom_range(65535);
      default: hold = act - $urandom_range(20000, 3);
    endcase
    if (hold < 0) hold = 0;
    case ($urandom_range(9))
      0: drop = 0;
      1: drop = 65535;
      2: drop = $urandom_range(65535);
      default: drop = $urandom_range(1500, 1);
    endcase
    case ($urandom_range(9))
      0: limit = 0;
      1: limit = 255;
      default: limit = $urandom_range(8, 1);
    endcase
    program_regs(act, hold, drop, limit, $urandom_range(65535));
  endtask

  // Next random reading: mostly drifting dose sequences, some starts, edges and noise
  task automatic random_reading;
    int pick, step;
    logic runoff;
    pick = $urandom_range(99);
    runoff = 1'($urandom_range(1));
    if (pick < 8) begin
      cur_rd = $urandom_range(65535);
    end else if (pick < 20) begin
      case ($urandom_range(5))
        0: cur_rd = act_v - 1;
        1: cur_rd = act_v;
        2: cur_rd = act_v + 1;
        3: cur_rd = hold_v - 1;
        4: cur_rd = hold_v;
        default: cur_rd = hold_v + 1;
      endcase
    end else if (pick < 35) begin
      cur_rd = $urandom_range(65535, act_v);
    end else begin
      step = $urandom_range(2 * drop_v + 16);
      if (step > 6000) step = $urandom_range(6000);
      if ($urandom_range(99) < 65) cur_rd = cur_rd - step;
      else cur_rd = cur_rd + step;
      runoff = ($urandom_range(99) < 15);
    end
    if (cur_rd < 0) cur_rd = 0;
    if (cur_rd > 65535) cur_rd = 65535;
    send_reading(cur_rd[15:0], runoff);
  endtask

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int ph, blk, n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle <= 34;
    recv_idle <= 88;

    // Directed: one full dose cycle of each ending
    program_regs(40000, 10000, 500, 3, 1234);
    send_reading(16'd0, 1'b1);        // hold band start, runoff ignored
    send_reading(16'd20000, 1'b0);    // wait band start
    send_reading(16'hFFFF, 1'b1);     // act start, runoff ignored
    send_reading(16'd65000, 1'b0);    // absorbed, still dry
    send_reading(16'd64800, 1'b1);    // small drop with runoff: passthrough
    send_reading(16'd50000, 1'b0);
    send_reading(16'd50100, 1'b0);    // wetness went backwards: inconclusive
    send_reading(16'd50000, 1'b0);
    send_reading(16'd49990, 1'b0);    // third pulse used: pulse bound
    send_reading(16'd45000, 1'b0);
    send_reading(16'd30000, 1'b1);    // absorbed into the wait band
    send_reading(16'd40000, 1'b0);    // exactly on the act threshold
    send_reading(16'd10000, 1'b0);    // exactly on the hold threshold
    drain();

    // Zero pulse limit ends a dry start at once
    program_regs(40000, 10000, 500, 0, 1234);
    send_reading(16'd60000, 1'b0);
    send_reading(16'd5000, 1'b1);
    drain();

    // Overlapping bands resolve to act; zero drop counts a flat reading as absorbed
    program_regs(1000, 5000, 0, 255, 0);
    send_reading(16'd3000, 1'b0);
    send_reading(16'd3000, 1'b1);
    drain();

    // Lower the limit below the pulses already given in the open cycle
    program_regs(1000, 5000, 65535, 1, 65535);
    send_reading(16'd3000, 1'b0);
    send_reading(16'hFFFF, 1'b0);
    send_reading(16'd0, 1'b0);        // largest possible drop still absorbs
    drain();

    // Everything in the act band
    program_regs(0, 65535, 1, 2, 7);
    send_reading(16'd0, 1'b0);
    send_reading(16'hFFFF, 1'b1);
    drain();

    // Random: three idling patterns, four register settings each
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle <= 34;
          recv_idle <= 88;
        end
        1: begin
          send_idle <= 88;
          recv_idle <= 34;
        end
        default: begin
          send_idle <= 0;
          recv_idle <= 0;
        end
      endcase
      for (blk = 0; blk < 4; blk++) begin
        drain();
        if (ph == 1 && blk == 3) program_regs(65535, 0, 65535, 255, 65535);
        else if (ph == 2 && blk == 3) program_regs(0, 0, 0, 0, 0);
        else random_regs();
        if (ph == 0 && blk == 0) hold_token <= hold_token + 1;
        for (n = 0; n < 86; n++) random_reading();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/brds_pkg.sv
hw/rtl/bounded_rewetting_dose_sequencer.sv
verif/brds_checker.sv
verif/tb_bounded_rewetting_dose_sequencer.sv
